[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

[hdl/mss_pkg.sv]
package mss_pkg;

	localparam int BYTE_W     = 8;
	localparam int SIG_BYTES  = 32;
	localparam int OUT_OFS_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PLEN_W     = 6;
	localparam int MASK_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd5;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_OFS_W-1:0] match_offset;
	} out_item_t;

	// signature and care mask as seen by every cell
	typedef struct packed {
		logic [SIG_BYTES-1:0][BYTE_W-1:0] pattern;
		logic [MASK_W-1:0]                care;
	} sig_cfg_t;

endpackage

[hdl/mss_cell.sv]
module mss_cell #(
	parameter int CELL_IDX = 0,
	parameter int LEN_W    = 6
) (
	input  logic                         clk,
	input  logic                         shift_en,
	input  logic [mss_pkg::BYTE_W-1:0]   byte_in,
	output logic [mss_pkg::BYTE_W-1:0]   byte_out,
	input  logic [LEN_W-1:0]             len,
	input  mss_pkg::sig_cfg_t            sig,
	output logic                         hit
);
	import mss_pkg::*;

	localparam int KW = (LEN_W + 1 > 6) ? LEN_W + 1 : 6;

	logic [BYTE_W-1:0] byte_q;
	logic [KW-1:0]     k_w;
	logic              in_use;
	logic              wild;
	logic [4:0]        sig_idx;

	// this cell holds window position CELL_IDX, which lines up with
	// signature byte len-1-CELL_IDX
	always_comb begin
		in_use  = KW'(len) > KW'(CELL_IDX);
		k_w     = KW'(len) - KW'(CELL_IDX) - KW'(1);
		sig_idx = k_w[4:0];
		wild    = !in_use || (k_w >= KW'(SIG_BYTES)) || !sig.care[sig_idx];
		hit     = wild || (byte_in == sig.pattern[sig_idx]);
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

[hdl/masked_signature_scanner.sv]
// A result beat is registered into out_data, or into the skid stage while the output is stalled.
// Throughput: one byte per cycle while in_stall is low; every window position is compared at once
// by the chain of cells as the byte shifts in.
// in_stall rises only when a result waits in the skid stage behind a stalled output.
// Reset: arst_n clears byte count, match flag, output beats and registers
// (pattern length resets to 1); window bytes are not reset.
module masked_signature_scanner #(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mss_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mss_pkg::out_item_t                out_data
);
	import mss_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

	sig_cfg_t          sig_q;
	logic [PLEN_W-1:0] plen_q;
	logic [LEN_W-1:0]  len_eff;
	logic [6:0]        len_raw;
	logic [6:0]        len_clip;

	logic [OFFSET_BITS-1:0] seen_q;
	logic [OFFSET_BITS-1:0] seen_nxt;
	logic [OFFSET_BITS-1:0] ofs_w;
	logic                   reported_q;

	logic [MAX_PATTERN:0][BYTE_W-1:0] chain_w;
	logic [MAX_PATTERN-1:0]           hits;

	logic      accept;
	logic      match;
	logic      res_valid;
	out_item_t res;
	out_item_t skid_q;
	logic      skid_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q  <= '0;
			plen_q <= PLEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LOW:    sig_q.pattern[7:0]   <= cfg_data;
				REG_PAT_SECOND: sig_q.pattern[15:8]  <= cfg_data;
				REG_PAT_THIRD:  sig_q.pattern[23:16] <= cfg_data;
				REG_PAT_HIGH:   sig_q.pattern[31:24] <= cfg_data;
				REG_CARE_MASK:  sig_q.care           <= cfg_data[MASK_W-1:0];
				REG_PAT_LEN:    plen_q               <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero length acts as one, lengths past the window clip to it
	always_comb begin
		len_raw = {1'b0, plen_q};
		if (plen_q == '0) begin
			len_clip = 7'd1;
		end else if (len_raw > 7'(MAX_PATTERN)) begin
			len_clip = 7'(MAX_PATTERN);
		end else begin
			len_clip = len_raw;
		end
		len_eff = LEN_W'(len_clip);
	end

	assign accept     = in_valid && !in_stall;
	assign chain_w[0] = in_data.data_byte;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
			mss_cell #(
				.CELL_IDX (gi),
				.LEN_W    (LEN_W)
			) u_cell (
				.clk      (clk),
				.shift_en (accept),
				.byte_in  (chain_w[gi]),
				.byte_out (chain_w[gi+1]),
				.len      (len_eff),
				.sig      (sig_q),
				.hit      (hits[gi])
			);
		end
	endgenerate

	always_comb begin
		seen_nxt  = (seen_q == CNT_MAX) ? seen_q : seen_q + OFFSET_BITS'(1);
		ofs_w     = seen_nxt - OFFSET_BITS'(len_eff);
		match     = !reported_q && (seen_nxt >= OFFSET_BITS'(len_eff)) && (&hits);
		res_valid = accept && (match || (in_data.last_byte && !reported_q));
		res.found        = match;
		res.match_offset = match ? OUT_OFS_W'(ofs_w) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				seen_q     <= seen_nxt;
				reported_q <= reported_q || match;
			end
		end
	end

	// output register plus one skid beat; input stalls while the skid is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			if (skid_valid_q) begin
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || !out_stall) begin
			out_data <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign in_stall = skid_valid_q;

endmodule

[hdl/mss_checker.sv]
`include "assert_macros.svh"

module mss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input mss_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input mss_pkg::out_item_t out_data
);
	import mss_pkg::*;

	// a held result beat stays offered
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
	// and keeps its payload
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
	// a not-found beat never carries an offset
	`ASSERT_ALWAYS(a_nf_zero, out_valid && !out_data.found |-> out_data.match_offset == '0, "not-found beat has offset")
	// input back-pressure only comes from a result stuck behind a stalled output
	`ASSERT_ALWAYS(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "input stall without output stall")

endmodule

bind masked_signature_scanner mss_checker u_mss_checker (.*);

[sim/tb_masked_signature_scanner.sv]
`timescale 1ns / 1ps

module tb_masked_signature_scanner;
	import mss_pkg::*;

	localparam int RANDOM_BYTES = 700;
	localparam int STUCK_LIMIT  = 2000;

	// indexes past the register file; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	localparam logic [CFG_IDX_W-1:0] WORD_REGS [4] = '{
		REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH
	};

	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_HIT, CHK_MISS} chk_t;

	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [BYTE_W-1:0]     data;
		logic                  last;
		chk_t                  chk;
		logic [OUT_OFS_W-1:0]  ofs;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [29] = '{
		// reset config: length 1, nothing compared, so every byte hits
		'{1'b0, '0, '0, 8'h00, 1'b0, CHK_HIT, 32'd0},
		'{1'b0, '0, '0, 8'hFF, 1'b1, CHK_NONE, 32'd0},
		'{1'b0, '0, '0, 8'h5A, 1'b1, CHK_HIT, 32'd0},   // hit on the last beat
		// length zero acts as one
		'{1'b1, REG_PAT_LEN, 64'd0, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_CARE_MASK, 64'd1, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_PAT_LOW, 64'h0123_4567_89AB_CDAB, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_UNUSED_6, '1, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_UNUSED_7, '1, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h00, 1'b0, CHK_NONE, 32'd0},
		'{1'b0, '0, '0, 8'hAB, 1'b0, CHK_HIT, 32'd1},
		'{1'b0, '0, '0, 8'h00, 1'b1, CHK_NONE, 32'd0},  // no second report
		'{1'b0, '0, '0, 8'h12, 1'b1, CHK_MISS, 32'd0},
		// oversize length clamps to 32; short image cannot match
		'{1'b1, REG_PAT_LEN, 64'd63, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_CARE_MASK, '1, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_PAT_HIGH, '1, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'hFF, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h7E, 1'b1, CHK_MISS, 32'd0},
		// 3-byte signature 11 ?? CC
		'{1'b1, REG_PAT_LEN, 64'd3, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_CARE_MASK, 64'd5, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b1, REG_PAT_LOW, 64'h0000_0000_00CC_5511, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h11, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h42, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'hCC, 1'b0, CHK_HIT, 32'd1},
		'{1'b0, '0, '0, 8'h55, 1'b1, CHK_NONE, 32'd0},
		'{1'b0, '0, '0, 8'h11, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'h00, 1'b0, CHK_PRED, 32'd0},
		'{1'b0, '0, '0, 8'hCC, 1'b1, CHK_HIT, 32'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// shadow of the scanner: registers and per-image scan state
	logic [3:0][63:0]      sig_words;
	logic [MASK_W-1:0]     care_bits;
	logic [PLEN_W-1:0]     len_reg;
	logic [BYTE_W-1:0]     win_bytes [32];
	logic [OUT_OFS_W-1:0]  img_count;
	logic                  hit_seen;

	out_item_t             expected_reports [$];
	out_item_t             want;
	int                    errors = 0;
	int                    items_sent = 0;
	int                    results_seen = 0;
	int                    phases = 0;
	int                    stuck_cycles = 0;
	bit                    quiet = 1'b0;

	masked_signature_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic int eff_len();
		int n;
		n = int'(len_reg);
		if (n == 0) n = 1;
		if (n > 32) n = 32;
		return n;
	endfunction

	function automatic logic [7:0] sig_byte(input int k);
		return sig_words[k >> 3][(k & 7) * 8 +: 8];
	endfunction

	// narrow alphabet makes stray and overlapping hits likely
	function automatic logic [7:0] pick_byte(input bit tight);
		if (!tight) return 8'($urandom_range(255));
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			default: return 8'hA5;
		endcase
	endfunction

	task automatic scan_predict(input logic [7:0] b, input logic last,
			output logic has, output out_item_t rep);
		int len;
		logic hit;
		has = 1'b0;
		rep = '0;
		len = eff_len();
		for (int i = 31; i > 0; i--) win_bytes[i] = win_bytes[i - 1];
		win_bytes[0] = b;
		if (img_count != '1) img_count++;
		if (!hit_seen && img_count >= len) begin
			hit = 1'b1;
			// win_bytes[len-1] is the oldest byte of the candidate, signature byte 0
			for (int k = 0; k < len; k++)
				if (care_bits[k] && win_bytes[len - 1 - k] != sig_byte(k)) hit = 1'b0;
			if (hit) begin
				hit_seen = 1'b1;
				has = 1'b1;
				rep = {1'b1, img_count - OUT_OFS_W'(len)};
			end
		end
		if (last) begin
			if (!hit_seen) has = 1'b1;
			foreach (win_bytes[i]) win_bytes[i] = '0;
			img_count = '0;
			hit_seen = 1'b0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PAT_LOW:    sig_words[0] = val;
			REG_PAT_SECOND: sig_words[1] = val;
			REG_PAT_THIRD:  sig_words[2] = val;
			REG_PAT_HIGH:   sig_words[3] = val;
			REG_CARE_MASK:  care_bits = val[MASK_W-1:0];
			REG_PAT_LEN:    len_reg = val[PLEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input chk_t chk,
			input logic [OUT_OFS_W-1:0] ofs);
		logic has;
		out_item_t got;
		cfg_we <= 1'b0;
		quiet = items_sent >= 250 && items_sent < 420;
		while (!quiet && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {b, last};
		do @(posedge clk); while (in_stall);
		scan_predict(b, last, has, got);
		case (chk)
			CHK_NONE: has = 1'b0;
			CHK_HIT: begin
				has = 1'b1;
				got = {1'b1, ofs};
			end
			CHK_MISS: begin
				has = 1'b1;
				got = '0;
			end
			default: ;
		endcase
		if (has) expected_reports.push_back(got);
		items_sent++;
	endtask

	// drain all reports, then let the pipe go quiet before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_image(input bit tight);
		logic [7:0] img [$];
		int len, n, pos, roll, k;
		len = eff_len();
		roll = $urandom_range(99);
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
		if (roll < 75 && n < len) n = len + $urandom_range(0, 6);
		for (int i = 0; i < n; i++) img.push_back(pick_byte(tight));
		if (roll < 75) begin
			pos = $urandom_range(0, n - len);
			for (int j = 0; j < len; j++)
				if (care_bits[j]) img[pos + j] = sig_byte(j);
			// near miss: flip one bit of the chosen byte if it is compared
			if (roll >= 60) begin
				k = $urandom_range(0, len - 1);
				if (care_bits[k]) img[pos + k] ^= 8'h01 << $urandom_range(7);
			end
		end
		for (int i = 0; i < n; i++) send_byte(img[i], i == n - 1, CHK_PRED, '0);
	endtask

	always @(posedge clk) out_stall <= !quiet && $urandom_range(99) < 19;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_reports.size() == 0) begin
				$error("unexpected beat: found %0d match_offset %0d",
					out_data.found, out_data.match_offset);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				if (out_data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, out_data.found);
					errors++;
				end
				if (out_data.match_offset !== want.match_offset) begin
					$error("match_offset: expected %0d, got %0d",
						want.match_offset, out_data.match_offset);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no beat moved for %0d cycles", STUCK_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic prev_wr;
		bit tight;
		int goal;
		logic [63:0] cfg_word;
		sig_words = '0;
		care_bits = '0;
		len_reg = PLEN_W'(1);
		foreach (win_bytes[i]) win_bytes[i] = '0;
		img_count = '0;
		hit_seen = 1'b0;
		prev_wr = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[r]) begin
			if (DIR_TABLE[r].wr) begin
				if (!prev_wr) settle();
				write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].val);
			end else begin
				send_byte(DIR_TABLE[r].data, DIR_TABLE[r].last, DIR_TABLE[r].chk,
					DIR_TABLE[r].ofs);
			end
			prev_wr = DIR_TABLE[r].wr;
		end

		goal = items_sent + RANDOM_BYTES;
		while (items_sent < goal) begin
			settle();
			phases++;
			tight = 1'($urandom_range(1));
			foreach (WORD_REGS[w]) begin
				case ($urandom_range(7))
					0: cfg_word = '0;
					1: cfg_word = '1;
					default: for (int b = 0; b < 8; b++) cfg_word[8 * b +: 8] = pick_byte(tight);
				endcase
				write_reg(WORD_REGS[w], cfg_word);
			end
			cfg_word = {$urandom, $urandom};
			case ($urandom_range(5))
				0: cfg_word[31:0] = '0;
				1: cfg_word[31:0] = '1;
				2: cfg_word[31:0] = $urandom & $urandom;
				default: ;
			endcase
			write_reg(REG_CARE_MASK, cfg_word);
			// upper data bits are junk on purpose
			cfg_word = {$urandom, $urandom};
			case ($urandom_range(9))
				0: cfg_word[5:0] = 6'd1;
				1: cfg_word[5:0] = 6'd32;
				2: cfg_word[5:0] = 6'd0;
				3: cfg_word[5:0] = 6'($urandom_range(33, 63));
				4, 5: cfg_word[5:0] = 6'($urandom_range(1, 4));
				default: cfg_word[5:0] = 6'($urandom_range(1, 32));
			endcase
			write_reg(REG_PAT_LEN, cfg_word);
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, {$urandom, $urandom});
			repeat ($urandom_range(1, 4)) send_image(tight);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("scanned %0d bytes over %0d register settings, %0d reports checked",
			items_sent, phases + 4, results_seen);
		$display("lengths 0..63, wildcard masks, hits, near misses and no-match images");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
